[hdl/adrp_pkg.sv]
// Shared types and constants for the ADRP/ADD to ADR relaxer.
// No dependencies; every other file of the block but adrp_if imports this package.
`default_nettype none

package adrp_pkg;

   localparam logic [31:0] ADRP_MASK = 32'h9f00_0000;
   localparam logic [31:0] ADRP_CODE = 32'h9000_0000;
   localparam logic [31:0] ADD_BASE  = 32'h9100_0000;
   localparam logic [31:0] ADD_MASK  = 32'hffc0_03ff;
   localparam logic [31:0] ADR_CODE  = 32'h1000_0000;
   localparam logic [31:0] NOP_WORD  = 32'hd503_201f;

   // Only the page-offset bits of an address matter for the rewrite.
   localparam int unsigned PAGE_BITS = 12;

   typedef enum logic [1:0] {
      ERR_NONE         = 2'd0,
      ERR_ADRP_AT_END  = 2'd1,
      ERR_STRAY_ADRP   = 2'd2,
      ERR_OUT_OF_RANGE = 2'd3
   } err_type;

   typedef struct packed {
      logic [31:0] word;
      err_type     err;
      logic        last;
   } rsp_item_type;

   // Up to two responses per request; slot 1 is only used together with slot 0.
   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

`default_nettype wire

[hdl/adrp_if.sv]
// Valid/ready channel interfaces for the relaxer's request and response sides.
// No dependencies.
`default_nettype none

interface adrp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] code_word;
   logic        section_end;

   modport source (output valid, output code_word, output section_end, input ready);
   modport sink   (input valid, input code_word, input section_end, output ready);
endinterface

interface adrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] code_word_out;
   logic [1:0]  error_code;
   logic        section_end_out;

   modport source (output valid, output code_word_out, output error_code,
                   output section_end_out, input ready);
   modport sink   (input valid, input code_word_out, input error_code,
                   input section_end_out, output ready);
endinterface

`default_nettype wire

[hdl/adrp_add_to_adr_relaxer_top.sv]
// An accepted request stays in the request register until the queue has room for it.
// Throughput: one request per cycle while the queue has room; an ADRP gives no response and
// the ADD after it gives two (ADR, NOP), so the response side also moves one word per cycle
// when drained. The rate is set by the combinational rewrite between the request register
// and the queue. Reset (synchronous, active high) empties the queue, clears the section
// state and sets the text base address to zero.
// Top level of the relaxer; depends on adrp_pkg, adrp_if, adrp_engine, adrp_rsp_queue.
`default_nettype none

module adrp_add_to_adr_relaxer_top import adrp_pkg::*; #(
   parameter int unsigned RSP_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [63:0] csr_wdata,
   adrp_req_if.sink         req_chan,
   adrp_rsp_if.source       rsp_chan
);

   push_type     push;
   logic         room_ok;
   rsp_item_type rsp_item;

   adrp_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_base_lo (csr_wdata[PAGE_BITS-1:0]),
      .req_valid   (req_chan.valid),
      .req_word    (req_chan.code_word),
      .req_last    (req_chan.section_end),
      .req_ready   (req_chan.ready),
      .room_ok     (room_ok),
      .push        (push)
   );

   adrp_rsp_queue #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room_ok   (room_ok),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_chan.code_word_out   = rsp_item.word;
   assign rsp_chan.error_code      = rsp_item.err;
   assign rsp_chan.section_end_out = rsp_item.last;

endmodule

`default_nettype wire

[hdl/adrp_engine.sv]
// Request register, section state and the single-pass rewrite of one code word.
// Depends on adrp_pkg.
`default_nettype none

module adrp_engine import adrp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [PAGE_BITS-1:0] csr_base_lo,
   input  wire logic                 req_valid,
   input  wire logic [31:0]          req_word,
   input  wire logic                 req_last,
   output logic                      req_ready,
   input  wire logic                 room_ok,
   output push_type                  push
);

   logic                 req_valid_ff, req_valid_in;
   logic [31:0]          req_word_ff;
   logic                 req_last_ff;
   logic [PAGE_BITS-1:0] base_lo_ff, base_lo_in;
   logic [PAGE_BITS-1:0] addr_lo_ff, addr_lo_in;
   logic                 held_ff, held_in;
   logic [31:0]          held_word_ff, held_word_in;
   logic                 dropping_ff, dropping_in;

   logic                 fire;
   logic [4:0]           reg_num;
   logic                 add_ok;
   logic                 is_adrp;
   logic [20:0]          imm21;
   logic [34:0]          off35;
   logic [PAGE_BITS-1:0] pc_lo;
   logic [34:0]          distance;
   logic                 in_range;
   logic [31:0]          adr_word;

   assign fire      = req_valid_ff && room_ok;
   assign req_ready = !req_valid_ff || fire;
   assign req_valid_in = req_ready ? req_valid : req_valid_ff;

   assign reg_num = held_word_ff[4:0];
   assign add_ok  = (req_word_ff & ADD_MASK) ==
                    (ADD_BASE | (32'(reg_num) << 5) | 32'(reg_num));
   assign is_adrp = (req_word_ff & ADRP_MASK) == ADRP_CODE;

   // The page base minus the ADRP address is just the page offset less the
   // low bits of that address, so the distance stays a narrow signed value.
   assign imm21    = {held_word_ff[23:5], held_word_ff[30:29]};
   assign off35    = {{2{imm21[20]}}, imm21, 12'h000};
   assign pc_lo    = addr_lo_ff - PAGE_BITS'(4);
   assign distance = off35 - 35'(pc_lo) + 35'(req_word_ff[21:10]);

   assign in_range = (distance[34:20] == '0) ||
                     ((&distance[34:20]) && (distance[19:0] != '0));
   assign adr_word = ADR_CODE | {distance[1:0], 30'h0} >> 1
                     | {8'h00, distance[20:2], 5'h00} | 32'(reg_num);

   always_comb begin
      base_lo_in   = base_lo_ff;
      addr_lo_in   = addr_lo_ff;
      held_in      = held_ff;
      held_word_in = held_word_ff;
      dropping_in  = dropping_ff;
      push         = '0;

      if (fire) begin
         if (dropping_ff) begin
            if (req_last_ff) begin
               dropping_in = 1'b0;
               held_in     = 1'b0;
               addr_lo_in  = base_lo_ff;
            end
         end else begin
            addr_lo_in = addr_lo_ff + PAGE_BITS'(4);
            if (held_ff) begin
               held_in = 1'b0;
               if (!add_ok || !in_range) begin
                  push.push0      = 1'b1;
                  push.item0.word = '0;
                  push.item0.err  = add_ok ? ERR_OUT_OF_RANGE : ERR_STRAY_ADRP;
                  push.item0.last = 1'b1;
                  dropping_in     = !req_last_ff;
               end else begin
                  push.push0      = 1'b1;
                  push.item0.word = adr_word;
                  push.item0.err  = ERR_NONE;
                  push.item0.last = 1'b0;
                  push.push1      = 1'b1;
                  push.item1.word = NOP_WORD;
                  push.item1.err  = ERR_NONE;
                  push.item1.last = req_last_ff;
               end
            end else if (is_adrp) begin
               if (req_last_ff) begin
                  push.push0      = 1'b1;
                  push.item0.word = '0;
                  push.item0.err  = ERR_ADRP_AT_END;
                  push.item0.last = 1'b1;
               end else begin
                  held_in      = 1'b1;
                  held_word_in = req_word_ff;
               end
            end else begin
               push.push0      = 1'b1;
               push.item0.word = req_word_ff;
               push.item0.err  = ERR_NONE;
               push.item0.last = req_last_ff;
            end
            if (req_last_ff) begin
               addr_lo_in = base_lo_ff;
            end
         end
      end

      if (csr_we) begin
         base_lo_in = csr_base_lo;
         addr_lo_in = csr_base_lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         base_lo_ff   <= '0;
         addr_lo_ff   <= '0;
         held_ff      <= 1'b0;
         dropping_ff  <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         base_lo_ff   <= base_lo_in;
         addr_lo_ff   <= addr_lo_in;
         held_ff      <= held_in;
         dropping_ff  <= dropping_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         req_word_ff <= req_word;
         req_last_ff <= req_last;
      end
      held_word_ff <= held_word_in;
   end

   a_pair_is_ok: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> (push.push0 && push.item0.err == ERR_NONE))
      else $error("second response pushed without a clean first one");

   a_push_needs_fire: assert property (@(posedge clock) disable iff (reset)
      !fire |-> !push.push0)
      else $error("response pushed without a processed request");

   a_error_drops: assert property (@(posedge clock) disable iff (reset)
      (push.push0 && push.item0.err != ERR_NONE && !req_last_ff && !csr_we)
      |=> dropping_ff)
      else $error("mid-section error did not start dropping");

   a_drop_is_silent: assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> !push.push0)
      else $error("response pushed while dropping");

endmodule

`default_nettype wire

[hdl/adrp_rsp_queue.sv]
// Small response queue that takes one or two responses per cycle.
// Depends on adrp_pkg.
`default_nettype none

module adrp_rsp_queue import adrp_pkg::*; #(
   parameter int unsigned RSP_DEPTH = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  push_type    push,
   output logic        room_ok,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int unsigned IW = $clog2(RSP_DEPTH);
   localparam int unsigned CW = $clog2(RSP_DEPTH + 1);

   rsp_item_type  mem_ff [RSP_DEPTH];
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [IW-1:0] tail_next;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
      wrap_inc = (p == IW'(RSP_DEPTH - 1)) ? '0 : p + IW'(1);
   endfunction

   assign tail_next = wrap_inc(tail_ff);
   // Room is judged on the worst case of a two-response request.
   assign room_ok   = count_ff <= CW'(RSP_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_item  = mem_ff[head_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      head_in  = pop ? wrap_inc(head_ff) : head_ff;
      tail_in  = tail_ff;
      if (push.push1) begin
         tail_in = wrap_inc(tail_next);
      end else if (push.push0) begin
         tail_in = tail_next;
      end
      count_in = count_ff + CW'(push.push0) + CW'(push.push1) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[tail_ff] <= push.item0;
      end
      if (push.push1) begin
         mem_ff[tail_next] <= push.item1;
      end
   end

endmodule

`default_nettype wire

[tb/adrp_relaxer_checker.sv]
`timescale 1ns / 100ps
// Response checker for the ADRP/ADD to ADR relaxer: watches the CSR port and both channels,
// predicts the rewritten words of every accepted request and compares them in order.
// Depends on adrp_pkg and adrp_if.

module adrp_relaxer_checker import adrp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [63:0] csr_wdata,
   adrp_req_if              req_mon,
   adrp_rsp_if              rsp_mon,
   output int               mismatches,
   output int               outstanding
);

   localparam logic [63:0] ADR_REACH = 64'h0000_0000_000f_ffff;
   localparam logic [63:0] NEG_REACH = 64'hffff_ffff_fff0_0001;
   localparam int          REPORT_LIMIT = 10;

   logic [63:0]  text_base;
   logic [63:0]  word_addr;
   logic         adrp_held;
   logic [31:0]  held_word;
   logic         dropping;
   rsp_item_type relaxed_words[$];

   task automatic restart_section();
      adrp_held = 1'b0;
      held_word = '0;
      dropping  = 1'b0;
      word_addr = text_base;
   endtask

   task automatic push_expected(input logic [31:0] word, input err_type err, input logic last);
      rsp_item_type item;
      item.word = word;
      item.err  = err;
      item.last = last;
      relaxed_words.push_back(item);
   endtask

   // An error gives one result and, unless it falls on the section end, drops the rest.
   task automatic post_error(input err_type err, input logic last);
      push_expected('0, err, 1'b1);
      if (last) begin
         restart_section();
      end else begin
         adrp_held = 1'b0;
         held_word = '0;
         dropping  = 1'b1;
      end
   endtask

   task automatic relax_word(input logic [31:0] w, input logic last);
      logic [4:0]  rd;
      logic [20:0] page_delta;
      logic [63:0] pc;
      logic [63:0] off;
      logic [63:0] dest;
      logic [63:0] distance;
      logic [31:0] adr;
      if (dropping) begin
         if (last) restart_section();
      end else begin
         word_addr = word_addr + 64'd4;
         if (adrp_held) begin
            rd = held_word[4:0];
            pc = word_addr - 64'd8;
            if ((w & ADD_MASK) != (ADD_BASE | {22'd0, rd, rd})) begin
               post_error(ERR_STRAY_ADRP, last);
            end else begin
               page_delta = {held_word[23:5], held_word[30:29]};
               off      = {{31{page_delta[20]}}, page_delta, 12'd0};
               dest     = ((pc + off) & ~64'hfff) + {52'd0, w[21:10]};
               distance = dest - pc;
               if (distance > ADR_REACH && distance < NEG_REACH) begin
                  post_error(ERR_OUT_OF_RANGE, last);
               end else begin
                  adr = ADR_CODE | {1'b0, distance[1:0], 29'd0}
                      | {8'd0, distance[20:2], 5'd0} | {27'd0, rd};
                  push_expected(adr, ERR_NONE, 1'b0);
                  push_expected(NOP_WORD, ERR_NONE, last);
                  adrp_held = 1'b0;
                  held_word = '0;
                  if (last) restart_section();
               end
            end
         end else if ((w & ADRP_MASK) == ADRP_CODE) begin
            if (last) begin
               post_error(ERR_ADRP_AT_END, 1'b1);
            end else begin
               adrp_held = 1'b1;
               held_word = w;
            end
         end else begin
            push_expected(w, ERR_NONE, last);
            if (last) restart_section();
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type due;
      if (reset) begin
         text_base = '0;
         restart_section();
         relaxed_words.delete();
      end else begin
         if (csr_we) begin
            text_base = csr_wdata;
            word_addr = csr_wdata;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (relaxed_words.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: unexpected response word=%h err=%0d end=%b", $realtime,
                           rsp_mon.code_word_out, rsp_mon.error_code,
                           rsp_mon.section_end_out);
               mismatches++;
            end else begin
               due = relaxed_words.pop_front();
               if (rsp_mon.code_word_out !== due.word || rsp_mon.error_code !== due.err
                   || rsp_mon.section_end_out !== due.last) begin
                  if (mismatches < REPORT_LIMIT)
                     $display("%0t: expected word=%h err=%0d end=%b, got word=%h err=%0d end=%b",
                              $realtime, due.word, due.err, due.last, rsp_mon.code_word_out,
                              rsp_mon.error_code, rsp_mon.section_end_out);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            relax_word(req_mon.code_word, req_mon.section_end);
      end
      outstanding = relaxed_words.size();
   end

endmodule

[tb/adrp_add_to_adr_relaxer_top_test.sv]
`timescale 1ns / 100ps
// Testbench top for the ADRP/ADD to ADR relaxer: clock, reset, request and response drivers,
// text base programming per phase and the final verdict.
// Depends on adrp_pkg, adrp_if, adrp_add_to_adr_relaxer_top and adrp_relaxer_checker.

module adrp_add_to_adr_relaxer_top_test;
   import adrp_pkg::*;

   localparam int RANDOM_ITEMS  = 1550;
   localparam int NUM_PHASES    = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int BURST_ITEMS   = 48;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [63:0] csr_wdata;
   int          mismatches;
   int          outstanding;
   int          sent;
   bit          burst;
   bit          hold_request;

   adrp_req_if req_chan();
   adrp_rsp_if rsp_chan();

   adrp_add_to_adr_relaxer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   adrp_relaxer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // ADRP with a signed 21-bit page delta split into immlo and immhi.
   function automatic logic [31:0] make_adrp(input logic [4:0] rd, input logic [20:0] delta);
      return ADRP_CODE | {1'b0, delta[1:0], 29'd0} | {8'd0, delta[20:2], 5'd0} | {27'd0, rd};
   endfunction

   function automatic logic [31:0] make_add(input logic [4:0] rd, input logic [4:0] rn,
                                            input logic [11:0] imm);
      return ADD_BASE | {10'd0, imm, 10'd0} | {22'd0, rn, 5'd0} | {27'd0, rd};
   endfunction

   function automatic logic [31:0] plain_word();
      logic [31:0] w;
      w = $urandom;
      if ((w & ADRP_MASK) == ADRP_CODE) w[28] = ~w[28];
      return w;
   endfunction

   task automatic send_word(input logic [31:0] word, input logic last);
      int unsigned gap;
      gap = burst ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.code_word   <= word;
      req_chan.section_end <= last;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      sent++;
   endtask

   // Words that give no response may still be inside the block once the count hits zero.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [63:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : rsp_drain
      int unsigned gap;
      int          served;
      bit          calm;
      rsp_chan.ready = 1'b0;
      served = 0;
      calm   = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (served % 48 == 0) calm = ($urandom_range(0, 3) == 0);
         gap = calm ? 0 : $urandom_range(0, 7);
         if (hold_request) begin
            gap = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (gap != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         served++;
      end
   end

   initial begin : stimulus
      int          phase;
      int          quota;
      int          units;
      int          burst_until;
      int unsigned pick;
      bit          paused;
      bit          closing;
      logic [4:0]  rd;
      logic [20:0] delta;
      logic [11:0] imm;
      logic [31:0] second;
      logic [63:0] base_value;

      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.code_word   = '0;
      req_chan.section_end = 1'b0;
      sent         = 0;
      burst        = 1'b0;
      hold_request = 1'b0;
      paused       = 1'b0;
      burst_until  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_base(64'd0);
      // Pass-through extremes, a good pair, then an out-of-range pair whose tail is dropped.
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hffff_ffff, 1'b0);
      send_word(make_adrp(5'd0, 21'd0), 1'b0);
      send_word(make_add(5'd0, 5'd0, 12'd0), 1'b0);
      send_word(make_adrp(5'd31, 21'h0f_ffff), 1'b0);
      send_word(make_add(5'd31, 5'd31, 12'hfff), 1'b0);
      send_word(make_adrp(5'd2, 21'd0), 1'b0);
      send_word(NOP_WORD, 1'b1);
      // Shifted ADD after an ADRP, on the section end.
      send_word(make_adrp(5'd5, 21'd1), 1'b0);
      send_word(make_add(5'd5, 5'd5, 12'h010) | 32'h0040_0000, 1'b1);
      // ADRP as the final word.
      send_word(make_adrp(5'd7, 21'h1f_ffff), 1'b1);
      // Two ADRPs in a row, then a dropped section end.
      send_word(make_adrp(5'd3, 21'h1f_ffff), 1'b0);
      send_word(make_adrp(5'd3, 21'd0), 1'b0);
      send_word(make_add(5'd3, 5'd3, 12'd0), 1'b1);
      // Reach limits, each pair at the start of a section so the ADRP sits at the base.
      send_word(make_adrp(5'd9, 21'd255), 1'b0);
      send_word(make_add(5'd9, 5'd9, 12'hfff), 1'b1);
      send_word(make_adrp(5'd9, 21'd256), 1'b0);
      send_word(make_add(5'd9, 5'd9, 12'd0), 1'b1);
      send_word(make_adrp(5'd9, 21'h1f_ff00), 1'b0);
      send_word(make_add(5'd9, 5'd9, 12'd1), 1'b1);
      send_word(make_adrp(5'd9, 21'h1f_ff00), 1'b0);
      send_word(make_add(5'd9, 5'd9, 12'd0), 1'b1);
      send_word(NOP_WORD, 1'b1);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       base_value = 64'hffff_ffff_ffff_ffff;
            1:       base_value = 64'hffff_ffff_ffff_fff4;
            3:       base_value = 64'h0000_0000_0000_0ff8;
            4:       base_value = {$urandom, $urandom} & ~64'h3;
            5:       base_value = 64'h8000_0000_0000_0000;
            7:       base_value = 64'd0;
            default: base_value = {$urandom, $urandom};
         endcase
         write_base(base_value);
         quota = sent + RANDOM_ITEMS / NUM_PHASES;
         if (phase == 2) begin
            // Stall the response side while requests keep coming back to back.
            hold_request = 1'b1;
            burst_until  = sent + BURST_ITEMS;
         end
         while (sent < quota) begin
            units = $urandom_range(1, 6);
            burst = (sent < burst_until) || ($urandom_range(0, 4) == 0);
            for (int u = 0; u < units; u++) begin
               closing = (u == units - 1);
               pick    = $urandom_range(0, 99);
               rd      = 5'($urandom);
               imm     = 12'($urandom);
               if ($urandom_range(0, 1) == 0)
                  delta = 21'($urandom_range(0, 4)) - 21'd2;
               else
                  delta = 21'($urandom_range(0, 510)) - 21'd255;
               if (pick < 38) begin
                  send_word(plain_word(), closing);
               end else if (pick < 88) begin
                  send_word(make_adrp(rd, delta), 1'b0);
                  send_word(make_add(rd, rd, imm), closing);
               end else if (pick < 92) begin
                  case ($urandom_range(0, 2))
                     0:       delta = 21'd256;
                     1:       delta = 21'h1f_ff00;
                     default: delta = 21'($urandom);
                  endcase
                  send_word(make_adrp(rd, delta), 1'b0);
                  send_word(make_add(rd, rd, imm), closing);
               end else if (pick < 96) begin
                  case ($urandom_range(0, 5))
                     0:       second = make_add(rd, rd ^ 5'($urandom_range(1, 31)), imm);
                     1:       second = make_add(rd ^ 5'($urandom_range(1, 31)), rd, imm);
                     2:       second = make_add(rd, rd, imm) | 32'h0040_0000;
                     3:       second = make_add(rd, rd, imm) & ~32'h8000_0000;
                     4:       second = make_adrp(rd, delta);
                     default: second = plain_word();
                  endcase
                  send_word(make_adrp(rd, delta), 1'b0);
                  send_word(second, closing);
               end else if (pick < 98) begin
                  send_word(make_adrp(rd, delta), closing);
               end else begin
                  send_word($urandom, closing);
               end
            end
            if (phase == 4 && !paused) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end

      burst = 1'b0;
      wait_drained();
      if (mismatches == 0 && outstanding == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

[filelist.f]
hdl/adrp_pkg.sv
hdl/adrp_if.sv
hdl/adrp_engine.sv
hdl/adrp_rsp_queue.sv
hdl/adrp_add_to_adr_relaxer_top.sv
tb/adrp_relaxer_checker.sv
tb/adrp_add_to_adr_relaxer_top_test.sv
